@@ design/sld_pkg.sv @@
// ----------------------------------------------------------------------------
// sld_pkg
// Shared constants and types for the sync / length / checksum deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

    // Sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // One result beat
    typedef struct packed {
        logic       is_frame_end;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       checksum_ok;
    } t_result;

endpackage

`default_nettype wire

@@ design/sld_core.sv @@
// ----------------------------------------------------------------------------
// sld_core
// Frame state machine: sync hunt, length capture, payload count and checksum.
// Produces at most one result per accepted byte, in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sld_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    output logic                 o_res_valid,
    output sld_pkg::t_result     o_res
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_length, n_length;
    logic [7:0] r_sum, n_sum;

    logic       in_payload;
    logic [7:0] sum_next;

    assign in_payload = (r_count < r_length);
    assign sum_next   = 8'(r_sum + i_rx_byte);

    // Next state and result for the current byte
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_length    = r_length;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == sld_pkg::SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase  = PH_HUNT;
                        n_count  = '0;
                        n_length = '0;
                        n_sum    = '0;
                    end
                end
                PH_SYNC2: begin
                    if (i_rx_byte == sld_pkg::SYNC_SECOND) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase  = PH_HUNT;
                        n_count  = '0;
                        n_length = '0;
                        n_sum    = '0;
                    end
                end
                PH_LEN: begin
                    n_length = i_rx_byte;
                    n_sum    = i_rx_byte;
                    n_count  = '0;
                    n_phase  = PH_BODY;
                end
                PH_BODY: begin
                    o_res_valid        = 1'b1;
                    o_res.frame_length = r_length;
                    if (in_payload) begin
                        o_res.payload_byte = i_rx_byte;
                        o_res.byte_index   = r_count;
                        n_sum              = sum_next;
                        n_count            = 8'(r_count + 8'd1);
                    end else begin
                        // checksum byte closes the frame
                        o_res.is_frame_end = 1'b1;
                        o_res.checksum_ok  = (sum_next == 8'd0);
                        n_phase            = PH_HUNT;
                        n_count            = '0;
                        n_length           = '0;
                        n_sum              = '0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= '0;
            r_length <= '0;
            r_sum    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_length <= n_length;
            r_sum    <= n_sum;
        end
    end

    // Count never runs past the declared length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_count <= r_length))
        else $error("payload count beyond frame length");

    // End beat returns to hunting
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_frame_end) |=> (r_phase == PH_HUNT))
        else $error("no return to hunt after frame end");

    // Hunting keeps counters clear
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_count == 8'd0 && r_length == 8'd0 && r_sum == 8'd0))
        else $error("counters not cleared while hunting");

endmodule

`default_nettype wire

@@ design/sld_outbuf.sv @@
// ----------------------------------------------------------------------------
// sld_outbuf
// Result register with a skid stage. Upstream stall comes from the skid
// flag only, so it is a plain register output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sld_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sld_pkg::t_result  i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sld_pkg::t_result       o_data
);

    logic             r_main_v;
    logic             r_skid_v;
    sld_pkg::t_result r_main;
    sld_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_v && !i_stall;
    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign o_full  = r_skid_v;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    // Beat data
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    // Skid only holds a beat behind a full main register
    a_skid_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid valid with empty main register");

    // Stalled skid beat is kept
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> (r_skid_v && $stable(r_skid)))
        else $error("skid beat lost under stall");

    // Push into a stalled full main lands in the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_skid_v && r_main_v && i_stall) |=> r_skid_v)
        else $error("beat dropped on stalled output");

endmodule

`default_nettype wire

@@ design/sync_length_checksum_deframer.sv @@
// Result beats are registered: in the result register, or the skid stage if stalled.
// Throughput: one byte per cycle while o_stall is low; the frame state advances per accepted byte.
// o_stall rises only when the skid stage holds a beat behind a stalled output.
// Reset (synchronous, active low) returns to sync hunting, clears counters
// and empties the result register and skid stage.
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Top level: byte-stream deframer with payload and end-of-frame result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_is_frame_end,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_byte_index,
    output logic [7:0]      o_frame_length,
    output logic            o_checksum_ok
);

    logic             accept;
    logic             res_valid;
    logic             buf_full;
    sld_pkg::t_result res;
    sld_pkg::t_result out_data;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    // Frame state machine
    sld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register and skid stage
    sld_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_is_frame_end = out_data.is_frame_end;
    assign o_payload_byte = out_data.payload_byte;
    assign o_byte_index   = out_data.byte_index;
    assign o_frame_length = out_data.frame_length;
    assign o_checksum_ok  = out_data.checksum_ok;

endmodule

`default_nettype wire
